// ----- rtl/kcd_pkg.sv -----
// Shared types and fixed field widths for the key chord detector.
package kcd_pkg;

  localparam int unsigned KEY_FIELD_BITS = 8;  // width of key_code on the input beat
  localparam int unsigned MASK_BITS      = 8;  // width of fired_mask on the result beat
  localparam int unsigned CFG_IDX_BITS   = 3;  // chord register index
  localparam int unsigned CNT_BITS       = 3;  // key count field at the bottom of a chord register

  typedef struct packed {
    logic [KEY_FIELD_BITS-1:0] key_code;
    logic                      is_release;
    logic                      is_repeat;
  } kcd_evt_t;

endpackage

// ----- rtl/kcd_in_if.sv -----
// Key event channel: valid/ready plus the key event payload.
interface kcd_in_if;
  logic                                valid;
  logic                                ready;
  logic [kcd_pkg::KEY_FIELD_BITS-1:0]  key_code;
  logic                                is_release;
  logic                                is_repeat;

  modport source (output valid, output key_code, output is_release, output is_repeat,
                  input ready);
  modport sink   (input valid, input key_code, input is_release, input is_repeat,
                  output ready);
endinterface

// ----- rtl/kcd_out_if.sv -----
// Result channel: valid/ready plus the fired trigger mask.
interface kcd_out_if;
  logic                           valid;
  logic                           ready;
  logic [kcd_pkg::MASK_BITS-1:0]  fired_mask;

  modport source (output valid, output fired_mask, input ready);
  modport sink   (input valid, input fired_mask, output ready);
endinterface

// ----- rtl/key_chord_detector.sv -----
// Key chord detector top level: input register, trigger units, result register.
//
//   channel  dir  handshake          payload
//   in_bus   in   valid/ready        key_code[7:0], is_release, is_repeat
//   out_bus  out  valid/ready        fired_mask[7:0]
//   cfg_*    in   cfg_wr_en only     cfg_idx[2:0], cfg_wdata[3+KEYS_PER_CHORD*KEY_BITS-1:0]
//
// One beat per cycle unless out_bus stalls; a beat moves from input to result register.
// The input register feeds all trigger units in parallel; held flags update as
// the beat moves into the result register.
// Synchronous active-low reset clears the chord table, held flags and valids.
// A stalled result holds the pipe; in_bus.ready stays high while the input
// register is empty or can move forward in the same cycle.
module key_chord_detector #(
  parameter int unsigned NUM_CHORDS     = 8,
  parameter int unsigned KEYS_PER_CHORD = 4,
  parameter int unsigned KEY_BITS       = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [kcd_pkg::CFG_IDX_BITS-1:0]  cfg_idx,
  input  logic [3+KEYS_PER_CHORD*KEY_BITS-1:0] cfg_wdata,
  kcd_in_if.sink                            in_bus,
  kcd_out_if.source                         out_bus
);

  localparam int unsigned CFG_W = kcd_pkg::CNT_BITS + KEYS_PER_CHORD * KEY_BITS;

  logic [CFG_W-1:0]             chord_r [NUM_CHORDS];
  logic [NUM_CHORDS-1:0]        clr;
  logic [NUM_CHORDS-1:0]        fire;
  kcd_pkg::kcd_evt_t            s1_evt_r;
  logic                         s1_valid_r;
  logic                         s1_valid_nxt;
  logic                         out_valid_r;
  logic                         out_valid_nxt;
  logic [kcd_pkg::MASK_BITS-1:0] out_mask_r;
  logic                         advance;
  logic                         in_acc;

  kcd_cfg_regs #(
    .NUM_CHORDS (NUM_CHORDS),
    .CFG_W      (CFG_W)
  ) u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cfg_wr_en),
    .wr_idx  (cfg_idx),
    .wr_data (cfg_wdata),
    .chord_r (chord_r),
    .clr     (clr)
  );

  assign advance        = s1_valid_r && (!out_valid_r || out_bus.ready);
  assign in_bus.ready   = !s1_valid_r || advance;
  assign in_acc         = in_bus.valid && in_bus.ready;

  for (genvar t = 0; t < NUM_CHORDS; t++) begin : g_chord
    kcd_chord_unit #(
      .KEYS_PER_CHORD (KEYS_PER_CHORD),
      .KEY_BITS       (KEY_BITS),
      .CFG_W          (CFG_W)
    ) u_unit (
      .clk     (clk),
      .rst_n   (rst_n),
      .chord   (chord_r[t]),
      .clr     (clr[t]),
      .advance (advance),
      .evt     (s1_evt_r),
      .fire    (fire[t])
    );
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_acc) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_bus.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_evt_r.key_code   <= in_bus.key_code;
      s1_evt_r.is_release <= in_bus.is_release;
      s1_evt_r.is_repeat  <= in_bus.is_repeat;
    end
    if (advance) begin
      // mask bits above NUM_CHORDS stay zero
      out_mask_r <= kcd_pkg::MASK_BITS'(fire);
    end
  end

  assign out_bus.valid      = out_valid_r;
  assign out_bus.fired_mask = out_mask_r;

endmodule

// ----- rtl/kcd_cfg_regs.sv -----
// Chord table registers with per-trigger clear strobes on write.
module kcd_cfg_regs #(
  parameter int unsigned NUM_CHORDS = 8,
  parameter int unsigned CFG_W      = 35
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              wr_en,
  input  logic [kcd_pkg::CFG_IDX_BITS-1:0]  wr_idx,
  input  logic [CFG_W-1:0]                  wr_data,
  output logic [CFG_W-1:0]                  chord_r [NUM_CHORDS],
  output logic [NUM_CHORDS-1:0]             clr
);

  for (genvar t = 0; t < NUM_CHORDS; t++) begin : g_reg
    // indexes at or above NUM_CHORDS never hit any entry
    assign clr[t] = wr_en && (wr_idx == kcd_pkg::CFG_IDX_BITS'(t));

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        chord_r[t] <= '0;
      end else if (clr[t]) begin
        chord_r[t] <= wr_data;
      end
    end
  end

endmodule

// ----- rtl/kcd_chord_unit.sv -----
// One trigger: slot match, held flag update and completion check.
module kcd_chord_unit #(
  parameter int unsigned KEYS_PER_CHORD = 4,
  parameter int unsigned KEY_BITS       = 8,
  parameter int unsigned CFG_W          = 3 + KEYS_PER_CHORD * KEY_BITS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [CFG_W-1:0]  chord,
  input  logic              clr,
  input  logic              advance,
  input  kcd_pkg::kcd_evt_t evt,
  output logic              fire
);

  logic [kcd_pkg::CNT_BITS-1:0] cnt;
  logic [kcd_pkg::CNT_BITS-1:0] n_act;
  logic [KEYS_PER_CHORD-1:0]    act;
  logic [KEYS_PER_CHORD-1:0]    match;
  logic [KEYS_PER_CHORD-1:0]    held_r;
  logic [KEYS_PER_CHORD-1:0]    held_nxt;

  assign cnt   = chord[kcd_pkg::CNT_BITS-1:0];
  assign n_act = (cnt > kcd_pkg::CNT_BITS'(KEYS_PER_CHORD)) ?
                 kcd_pkg::CNT_BITS'(KEYS_PER_CHORD) : cnt;

  for (genvar k = 0; k < KEYS_PER_CHORD; k++) begin : g_slot
    assign act[k]   = kcd_pkg::CNT_BITS'(k) < n_act;
    // slot code is zero-extended, so keys wider than the slot never match
    assign match[k] = act[k] && (evt.key_code ==
                      kcd_pkg::KEY_FIELD_BITS'(chord[kcd_pkg::CNT_BITS + k*KEY_BITS +: KEY_BITS]));
  end

  always_comb begin
    held_nxt = held_r;
    if (evt.is_release) begin
      held_nxt = held_r & ~match;
    end else if (!evt.is_repeat) begin
      held_nxt = (match != '0) ? (held_r | match) : '0;
    end
  end

  assign fire = !evt.is_release && !evt.is_repeat && (n_act != '0) && (&(held_nxt | ~act));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= '0;
    end else if (clr) begin
      held_r <= '0;
    end else if (advance) begin
      held_r <= held_nxt;
    end
  end

endmodule

// ----- dv/tb_key_chord_detector.sv -----
// Testbench for key_chord_detector: directed and random key events checked against a predictor.
`timescale 1ns / 1ps

module tb_key_chord_detector;

  localparam int unsigned NUM_CHORDS     = 8;
  localparam int unsigned KEYS_PER_CHORD = 4;
  localparam int unsigned KEY_BITS       = 8;
  localparam int unsigned CHORD_W        = 3 + KEYS_PER_CHORD * KEY_BITS;
  localparam int unsigned RPT_LIMIT      = 10;
  localparam int unsigned ITEMS_PER_PHASE = 185;
  localparam int unsigned NUM_PHASES     = 6;

  // keeps the chord table and held flags, predicts one fired mask per accepted beat
  class chord_scoreboard;
    logic [CHORD_W-1:0]        chord_tbl [NUM_CHORDS];
    logic [KEYS_PER_CHORD-1:0] held      [NUM_CHORDS];
    logic [kcd_pkg::MASK_BITS-1:0] pending_masks [$];
    int unsigned errors;
    int unsigned checked;
    int unsigned fired_beats;
    int unsigned cfg_writes;

    function new();
      foreach (chord_tbl[t]) begin
        chord_tbl[t] = '0;
        held[t]      = '0;
      end
      errors      = 0;
      checked     = 0;
      fired_beats = 0;
      cfg_writes  = 0;
    endfunction

    function int unsigned live_slots(int unsigned t);
      int unsigned n;
      n = chord_tbl[t][kcd_pkg::CNT_BITS-1:0];
      return (n > KEYS_PER_CHORD) ? KEYS_PER_CHORD : n;
    endfunction

    function logic [KEYS_PER_CHORD-1:0] slot_hits(int unsigned t,
                                                  logic [kcd_pkg::KEY_FIELD_BITS-1:0] key);
      logic [KEYS_PER_CHORD-1:0] m;
      int unsigned n;
      m = '0;
      n = live_slots(t);
      for (int unsigned k = 0; k < n; k++) begin
        if (int'(chord_tbl[t][3+k*KEY_BITS +: KEY_BITS]) == int'(key))
          m[k] = 1'b1;
      end
      return m;
    endfunction

    function void load_chord(int unsigned idx, logic [CHORD_W-1:0] v);
      cfg_writes++;
      if (idx < NUM_CHORDS) begin
        chord_tbl[idx] = v;
        held[idx]      = '0;
      end
    endfunction

    function void note_event(kcd_pkg::kcd_evt_t e);
      logic [KEYS_PER_CHORD-1:0] m;
      logic [KEYS_PER_CHORD-1:0] full;
      logic [kcd_pkg::MASK_BITS-1:0] mask;
      int unsigned n;
      mask = '0;
      if (e.is_release) begin
        for (int unsigned t = 0; t < NUM_CHORDS; t++)
          held[t] = held[t] & ~slot_hits(t, e.key_code);
      end else if (!e.is_repeat) begin
        for (int unsigned t = 0; t < NUM_CHORDS; t++) begin
          m = slot_hits(t, e.key_code);
          held[t] = (m != 0) ? (held[t] | m) : '0;
        end
        for (int unsigned t = 0; t < NUM_CHORDS; t++) begin
          n    = live_slots(t);
          full = KEYS_PER_CHORD'((1 << n) - 1);
          if (n != 0 && (held[t] & full) == full)
            mask[t] = 1'b1;
        end
      end
      pending_masks = {pending_masks, mask};
    endfunction

    function void check_mask(logic [kcd_pkg::MASK_BITS-1:0] got);
      logic [kcd_pkg::MASK_BITS-1:0] want;
      if (pending_masks.size() == 0) begin
        errors++;
        if (errors <= RPT_LIMIT)
          $display("error: result beat %02h with nothing expected", got);
        return;
      end
      want = pending_masks.pop_front();
      checked++;
      if (want != 0)
        fired_beats++;
      if (got !== want) begin
        errors++;
        if (errors <= RPT_LIMIT)
          $display("mismatch on result %0d: fired_mask expected %02h got %02h",
                   checked, want, got);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_wr_en;
  logic [kcd_pkg::CFG_IDX_BITS-1:0] cfg_idx;
  logic [CHORD_W-1:0] cfg_wdata;

  kcd_in_if  in_if ();
  kcd_out_if out_if ();

  key_chord_detector #(
    .NUM_CHORDS(NUM_CHORDS),
    .KEYS_PER_CHORD(KEYS_PER_CHORD),
    .KEY_BITS(KEY_BITS)
  ) i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en),
    .cfg_idx(cfg_idx),
    .cfg_wdata(cfg_wdata),
    .in_bus(in_if),
    .out_bus(out_if)
  );

  chord_scoreboard sb = new();
  int unsigned src_idle = 0;
  int unsigned dst_idle = 0;
  int unsigned sent     = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // monitor: both channels sampled at the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_if.valid && in_if.ready)
        sb.note_event('{key_code: in_if.key_code, is_release: in_if.is_release,
                        is_repeat: in_if.is_repeat});
      if (out_if.valid && out_if.ready)
        sb.check_mask(out_if.fired_mask);
    end
  end

  // result side backpressure
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_if.ready = ($urandom_range(99) >= dst_idle);
    end
  end

  initial begin
    #(12 * 400000);
    $display("timeout: run did not drain");
    $display("== FAIL ==");
    $finish;
  end

  function automatic logic [CHORD_W-1:0] pack_chord(int unsigned cnt, logic [7:0] k0,
                                                    logic [7:0] k1, logic [7:0] k2,
                                                    logic [7:0] k3);
    return {k3, k2, k1, k0, kcd_pkg::CNT_BITS'(cnt)};
  endfunction

  task automatic write_chord(int unsigned idx, logic [CHORD_W-1:0] v);
    @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_idx   = kcd_pkg::CFG_IDX_BITS'(idx);
    cfg_wdata = v;
    @(posedge clk);
    sb.load_chord(idx, v);
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  task automatic send_key(logic [7:0] key, logic rel, logic rpt);
    @(negedge clk);
    while ($urandom_range(99) < src_idle) begin
      in_if.valid = 1'b0;
      @(negedge clk);
    end
    in_if.valid      = 1'b1;
    in_if.key_code   = key;
    in_if.is_release = rel;
    in_if.is_repeat  = rpt;
    do @(posedge clk); while (!in_if.ready);
    sent++;
  endtask

  task automatic drain();
    @(negedge clk);
    in_if.valid = 1'b0;
    while (sb.pending_masks.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // a press sequence on one trigger's keys, shuffled, with stray repeats and breaks
  task automatic play_chord(logic [7:0] pool [6]);
    logic [7:0] keys [KEYS_PER_CHORD];
    logic [7:0] tmp;
    int unsigned t;
    int unsigned n;
    int unsigned j;
    t = $urandom_range(NUM_CHORDS - 1);
    n = sb.live_slots(t);
    if (n == 0)
      n = $urandom_range(1, KEYS_PER_CHORD);
    for (int unsigned k = 0; k < KEYS_PER_CHORD; k++)
      keys[k] = sb.chord_tbl[t][3+k*KEY_BITS +: KEY_BITS];
    for (int unsigned k = 0; k < n; k++) begin
      j = $urandom_range(n - 1);
      tmp = keys[k]; keys[k] = keys[j]; keys[j] = tmp;
    end
    for (int unsigned k = 0; k < n; k++) begin
      send_key(keys[k], 1'b0, 1'b0);
      if ($urandom_range(9) < 2)
        send_key(keys[k], 1'b0, 1'b1);
      if ($urandom_range(9) == 0)
        send_key(pool[$urandom_range(5)], 1'b0, 1'b0);
    end
    if ($urandom_range(1) == 0) begin
      for (int unsigned k = 0; k < n; k++)
        send_key(keys[n-1-k], 1'b1, 1'($urandom_range(1)));
    end else begin
      send_key(keys[$urandom_range(n - 1)], 1'b1, 1'b0);
    end
  endtask

  initial begin
    logic [7:0] pool [6];
    int unsigned r;
    int unsigned target;

    rst_n           = 1'b0;
    cfg_wr_en       = 1'b0;
    cfg_idx         = '0;
    cfg_wdata       = '0;
    in_if.valid     = 1'b0;
    in_if.key_code  = '0;
    in_if.is_release = 1'b0;
    in_if.is_repeat = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed part, receiver and sender never idle
    send_key(8'h00, 1'b0, 1'b0);   // empty table after reset
    drain();
    write_chord(0, pack_chord(2, 8'h11, 8'h22, 8'h33, 8'h11));  // slot beyond count
    write_chord(1, pack_chord(0, 8'h11, 8'h22, 8'h00, 8'h00));  // disabled
    write_chord(2, pack_chord(7, 8'h00, 8'hFF, 8'h44, 8'h55));  // count saturates
    write_chord(3, pack_chord(1, 8'hFF, 8'h00, 8'h00, 8'h00));
    write_chord(4, pack_chord(3, 8'h22, 8'h22, 8'h66, 8'h00));  // duplicate key
    write_chord(5, pack_chord(4, 8'h77, 8'h77, 8'h77, 8'h77));
    write_chord(6, pack_chord(5, 8'h11, 8'h22, 8'h00, 8'hFF));
    write_chord(7, pack_chord(0, 8'h00, 8'h00, 8'h00, 8'h00));
    send_key(8'h11, 1'b0, 1'b0);
    send_key(8'h22, 1'b0, 1'b0);
    send_key(8'h22, 1'b0, 1'b1);
    send_key(8'h22, 1'b1, 1'b0);
    send_key(8'h22, 1'b0, 1'b0);
    send_key(8'h33, 1'b0, 1'b0);
    send_key(8'h00, 1'b0, 1'b0);
    send_key(8'hFF, 1'b0, 1'b0);
    send_key(8'h44, 1'b0, 1'b0);
    send_key(8'h55, 1'b0, 1'b0);
    send_key(8'h55, 1'b1, 1'b1);   // repeat flag on a release
    send_key(8'h55, 1'b0, 1'b0);
    send_key(8'h66, 1'b0, 1'b0);
    send_key(8'h77, 1'b0, 1'b0);
    send_key(8'hA5, 1'b0, 1'b0);
    drain();
    write_chord(0, pack_chord(2, 8'h11, 8'h22, 8'h33, 8'h11));  // write clears held flags
    send_key(8'h22, 1'b0, 1'b0);
    drain();
    for (int unsigned t = 0; t < NUM_CHORDS; t++)
      write_chord(t, '1);
    send_key(8'hFF, 1'b0, 1'b0);
    send_key(8'hFF, 1'b1, 1'b0);
    send_key(8'hFF, 1'b0, 1'b1);
    drain();
    for (int unsigned t = 0; t < NUM_CHORDS; t++)
      write_chord(t, '0);
    send_key(8'h00, 1'b0, 1'b0);
    send_key(8'h00, 1'b1, 1'b1);
    drain();

    // random phases: two table settings per idle mode
    for (int unsigned p = 0; p < NUM_PHASES; p++) begin
      case (p / 2)
        0: begin src_idle = 30; dst_idle = 83; end
        1: begin src_idle = 83; dst_idle = 30; end
        default: begin src_idle = 0; dst_idle = 0; end
      endcase
      foreach (pool[i])
        pool[i] = 8'($urandom_range(255));
      if (p % 2 == 0) begin
        pool[0] = 8'h00;
        pool[1] = 8'hFF;
      end
      for (int unsigned t = 0; t < NUM_CHORDS; t++)
        write_chord(t, pack_chord($urandom_range(7), pool[$urandom_range(5)],
                                  pool[$urandom_range(5)], pool[$urandom_range(5)],
                                  pool[$urandom_range(5)]));
      target = sent + ITEMS_PER_PHASE;
      while (sent < target) begin
        r = $urandom_range(99);
        if (r < 70)
          play_chord(pool);
        else if (r < 85)
          send_key(pool[$urandom_range(5)], 1'($urandom_range(1)), 1'($urandom_range(1)));
        else
          send_key(8'($urandom_range(255)), 1'($urandom_range(1)), 1'($urandom_range(1)));
      end
      drain();
    end

    repeat (10) @(posedge clk);
    $display("covered %0d key beats, %0d results checked, %0d with a chord fired",
             sent, sb.checked, sb.fired_beats);
    $display("%0d table writes over directed and %0d random phases, %0d errors",
             sb.cfg_writes, NUM_PHASES, sb.errors);
    if (sb.errors == 0 && sb.pending_masks.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/kcd_pkg.sv
rtl/kcd_in_if.sv
rtl/kcd_out_if.sv
rtl/kcd_cfg_regs.sv
rtl/kcd_chord_unit.sv
rtl/key_chord_detector.sv
dv/tb_key_chord_detector.sv
